### design/gmrp_pkg.sv
// ---------------------------------------------------------------------------
// gmrp_pkg: shared types and constants for the mask rectangle packer
// Grid limits, field widths, register indexes and the command/status words
// that join the controller and the datapath.
// ---------------------------------------------------------------------------
package gmrp_pkg;

    // Grid limits
    localparam int MAX_COLS   = 8;
    localparam int MAX_ROWS   = 8;
    localparam int ROW_W      = MAX_COLS;
    localparam int IDX_W      = $clog2(MAX_ROWS);

    // Field widths
    localparam int DIM_W      = 4;
    localparam int TILE_W     = 11;
    localparam int COORD_W    = 13;
    localparam int PROD_W     = DIM_W + TILE_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int CFG_IDX_W  = 3;

    // Result cap per mask
    localparam int RESULT_MAX = 32;
    localparam int RCNT_W     = $clog2(RESULT_MAX) + 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH   = 3'd0,
        REG_GRID_HEIGHT  = 3'd1,
        REG_TILE_SIZE    = 3'd2,
        REG_ORIGIN_X     = 3'd3,
        REG_ORIGIN_Y     = 3'd4,
        REG_FRAME_WIDTH  = 3'd5,
        REG_FRAME_HEIGHT = 3'd6
    } cfg_reg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // store the incoming row word
        logic load;     // copy the mask into the work rows
        logic shift;    // drop the empty top work row
        logic grab;     // take the next rectangle and clear its cells
        logic mul;      // form the pixel offsets
        logic eval;     // clip and queue the rectangle
        logic flush;    // send the final word of the mask
    } gmrp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pack_now;    // incoming row completes the mask
        logic work_empty;  // no set cell is left
        logic row0_empty;  // top work row has no set cell
    } gmrp_stat_t;

    // Clamp a grid dimension into 1..maxv
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] res;
        if (v == '0)
            res = DIM_W'(1);
        else if (v > maxv)
            res = maxv;
        else
            res = v;
        return res;
    endfunction

endpackage

### design/gmrp_ctrl.sv
// ---------------------------------------------------------------------------
// gmrp_ctrl: sequencer of the mask rectangle packer
// Accepts row words, and after the last row steps the datapath through
// find, multiply and clip for every rectangle, then flushes the last word.
// ---------------------------------------------------------------------------
module gmrp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  gmrp_pkg::gmrp_stat_t stat,
    output logic                 busy,
    output gmrp_pkg::gmrp_cmd_t  cmd
);
    import gmrp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FIND  = 5'b00010,
        S_MUL   = 5'b00100,
        S_EVAL  = 5'b01000,
        S_FLUSH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (stat.pack_now)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_FIND;
                    end
                end
            end
            S_FIND:
            begin
                if (stat.work_empty)
                begin
                    state_next = S_FLUSH;
                end
                else if (stat.row0_empty)
                begin
                    cmd.shift = 1'b1;
                end
                else
                begin
                    cmd.grab   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_FIND;
            end
            S_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

### design/gmrp_dpath.sv
// ---------------------------------------------------------------------------
// gmrp_dpath: datapath of the mask rectangle packer
// Holds the mask rows and the working copy, finds and clears rectangles,
// converts them to clipped pixel coordinates and drives the result word.
// ---------------------------------------------------------------------------
module gmrp_dpath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  gmrp_pkg::gmrp_cmd_t                   cmd,
    output gmrp_pkg::gmrp_stat_t                  stat,
    input  logic [gmrp_pkg::ROW_W-1:0]            row_bits,
    input  logic [gmrp_pkg::DIM_W-1:0]            grid_width,
    input  logic [gmrp_pkg::DIM_W-1:0]            grid_height,
    input  logic [gmrp_pkg::TILE_W-1:0]           tile_size,
    input  logic signed [gmrp_pkg::COORD_W-1:0]   origin_x,
    input  logic signed [gmrp_pkg::COORD_W-1:0]   origin_y,
    input  logic [gmrp_pkg::COORD_W-1:0]          frame_width,
    input  logic [gmrp_pkg::COORD_W-1:0]          frame_height,
    output logic                                  strobe,
    output logic [gmrp_pkg::COORD_W-1:0]          rect_left,
    output logic [gmrp_pkg::COORD_W-1:0]          rect_top,
    output logic [gmrp_pkg::COORD_W-1:0]          rect_right,
    output logic [gmrp_pkg::COORD_W-1:0]          rect_bottom,
    output logic                                  rect_valid,
    output logic                                  last_rect
);
    import gmrp_pkg::*;

    // Mask store and working rows
    logic [ROW_W-1:0]   mask_reg [MAX_ROWS];
    logic [ROW_W-1:0]   work_reg [MAX_ROWS];
    logic [ROW_W-1:0]   load_row [MAX_ROWS];
    logic [DIM_W-1:0]   row_count_reg;
    logic [DIM_W-1:0]   row_count_next;

    // Effective grid
    logic [DIM_W-1:0]   gw;
    logic [DIM_W-1:0]   gh;
    logic [ROW_W-1:0]   colmask;

    // Rectangle finder
    logic               found;
    logic               open;
    logic               grow;
    logic [DIM_W-1:0]   gx;
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [ROW_W-1:0]   run;
    logic               any_set;

    logic [DIM_W-1:0]   gx_reg;
    logic [DIM_W-1:0]   w_reg;
    logic [DIM_W-1:0]   gy_reg;
    logic [DIM_W-1:0]   h_reg;

    // Pixel offsets
    logic [PROD_W-1:0]  pl_reg;
    logic [PROD_W-1:0]  pr_reg;
    logic [PROD_W-1:0]  pt_reg;
    logic [PROD_W-1:0]  pb_reg;

    // Clip
    logic signed [SUM_W-1:0] ox_s;
    logic signed [SUM_W-1:0] oy_s;
    logic signed [SUM_W-1:0] fw_s;
    logic signed [SUM_W-1:0] fh_s;
    logic signed [SUM_W-1:0] l_s;
    logic signed [SUM_W-1:0] t_s;
    logic signed [SUM_W-1:0] r_s;
    logic signed [SUM_W-1:0] b_s;
    logic signed [SUM_W-1:0] lc;
    logic signed [SUM_W-1:0] tc;
    logic signed [SUM_W-1:0] rc;
    logic signed [SUM_W-1:0] bc;
    logic                    rect_ok;
    logic                    take;

    // Pending rectangle and result count
    logic               pend_valid_reg;
    logic [COORD_W-1:0] pend_l_reg;
    logic [COORD_W-1:0] pend_t_reg;
    logic [COORD_W-1:0] pend_r_reg;
    logic [COORD_W-1:0] pend_b_reg;
    logic [RCNT_W-1:0]  cnt_reg;

    // Output word
    logic               strobe_reg;
    logic [COORD_W-1:0] out_l_reg;
    logic [COORD_W-1:0] out_t_reg;
    logic [COORD_W-1:0] out_r_reg;
    logic [COORD_W-1:0] out_b_reg;
    logic               out_valid_reg;
    logic               out_last_reg;

    // Effective grid size and column mask
    assign gw = clamp_dim(grid_width, DIM_W'(MAX_COLS));
    assign gh = clamp_dim(grid_height, DIM_W'(MAX_ROWS));

    always_comb
    begin
        for (int i = 0; i < ROW_W; i++)
        begin
            colmask[i] = (DIM_W'(i) < gw);
        end
    end

    // Row counter: wrap once the mask is complete
    assign row_count_next = row_count_reg + DIM_W'(1);
    assign stat.pack_now  = (row_count_next >= gh);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
        end
        else if (cmd.accept)
        begin
            row_count_reg <= stat.pack_now ? '0 : row_count_next;
        end
    end

    // Store the incoming row
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mask_reg[row_count_reg[IDX_W-1:0]] <= row_bits;
        end
    end

    // Working copy: incoming row merged, unused rows and columns zeroed
    always_comb
    begin
        for (int i = 0; i < MAX_ROWS; i++)
        begin
            if (DIM_W'(i) >= gh)
                load_row[i] = '0;
            else if (IDX_W'(i) == row_count_reg[IDX_W-1:0])
                load_row[i] = row_bits & colmask;
            else
                load_row[i] = mask_reg[i] & colmask;
        end
    end

    // Find the lowest set cell of the top row, its run and its height
    always_comb
    begin
        found = 1'b0;
        gx    = '0;
        for (int i = 0; i < ROW_W; i++)
        begin
            if (!found && work_reg[0][i])
            begin
                found = 1'b1;
                gx    = DIM_W'(i);
            end
        end
        run  = '0;
        w    = '0;
        open = 1'b1;
        for (int i = 0; i < ROW_W; i++)
        begin
            if (open && (DIM_W'(i) >= gx))
            begin
                if (work_reg[0][i])
                begin
                    run[i] = 1'b1;
                    w      = w + DIM_W'(1);
                end
                else
                begin
                    open = 1'b0;
                end
            end
        end
        h    = DIM_W'(1);
        grow = 1'b1;
        for (int i = 1; i < MAX_ROWS; i++)
        begin
            if (grow && ((work_reg[i] & run) == run))
                h = h + DIM_W'(1);
            else
                grow = 1'b0;
        end
    end

    // Status of the working rows
    always_comb
    begin
        any_set = 1'b0;
        for (int i = 0; i < MAX_ROWS; i++)
        begin
            any_set = any_set | (|work_reg[i]);
        end
    end

    assign stat.work_empty = !any_set;
    assign stat.row0_empty = (work_reg[0] == '0);

    // Update the working rows
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                work_reg[i] <= load_row[i];
            end
        end
        else if (cmd.shift)
        begin
            for (int i = 0; i < MAX_ROWS - 1; i++)
            begin
                work_reg[i] <= work_reg[i + 1];
            end
            work_reg[MAX_ROWS - 1] <= '0;
        end
        else if (cmd.grab)
        begin
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                if (DIM_W'(i) < h)
                    work_reg[i] <= work_reg[i] & ~run;
            end
        end
    end

    // Hold the cell position and size of the rectangle
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            gy_reg <= '0;
        end
        else if (cmd.shift)
        begin
            gy_reg <= gy_reg + DIM_W'(1);
        end
        if (cmd.grab)
        begin
            gx_reg <= gx;
            w_reg  <= w;
            h_reg  <= h;
        end
    end

    // Cell indexes times tile size
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            pl_reg <= {{TILE_W{1'b0}}, gx_reg} * {{DIM_W{1'b0}}, tile_size};
            pr_reg <= {{TILE_W{1'b0}}, gx_reg + w_reg} * {{DIM_W{1'b0}}, tile_size};
            pt_reg <= {{TILE_W{1'b0}}, gy_reg} * {{DIM_W{1'b0}}, tile_size};
            pb_reg <= {{TILE_W{1'b0}}, gy_reg + h_reg} * {{DIM_W{1'b0}}, tile_size};
        end
    end

    // Add the origin and clip to the framebuffer
    always_comb
    begin
        ox_s = {{(SUM_W - COORD_W){origin_x[COORD_W-1]}}, origin_x};
        oy_s = {{(SUM_W - COORD_W){origin_y[COORD_W-1]}}, origin_y};
        fw_s = {{(SUM_W - COORD_W){1'b0}}, frame_width};
        fh_s = {{(SUM_W - COORD_W){1'b0}}, frame_height};
        l_s  = ox_s + {{(SUM_W - PROD_W){1'b0}}, pl_reg};
        r_s  = ox_s + {{(SUM_W - PROD_W){1'b0}}, pr_reg};
        t_s  = oy_s + {{(SUM_W - PROD_W){1'b0}}, pt_reg};
        b_s  = oy_s + {{(SUM_W - PROD_W){1'b0}}, pb_reg};
        lc   = l_s[SUM_W-1] ? '0 : l_s;
        tc   = t_s[SUM_W-1] ? '0 : t_s;
        rc   = (r_s > fw_s) ? fw_s : r_s;
        bc   = (b_s > fh_s) ? fh_s : b_s;
        rect_ok = (rc > lc) && (bc > tc);
    end

    assign take = cmd.eval && rect_ok && (cnt_reg < RCNT_W'(RESULT_MAX));

    // Pending flag, result count and output strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            strobe_reg <= (take && pend_valid_reg) || cmd.flush;
            if (cmd.load || cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
                cnt_reg        <= '0;
            end
            else if (take)
            begin
                pend_valid_reg <= 1'b1;
                cnt_reg        <= cnt_reg + RCNT_W'(1);
            end
        end
    end

    // Queue the new rectangle, drive out the one before it
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pend_l_reg <= lc[COORD_W-1:0];
            pend_t_reg <= tc[COORD_W-1:0];
            pend_r_reg <= rc[COORD_W-1:0];
            pend_b_reg <= bc[COORD_W-1:0];
        end
        if ((take && pend_valid_reg) || (cmd.flush && pend_valid_reg))
        begin
            out_l_reg     <= pend_l_reg;
            out_t_reg     <= pend_t_reg;
            out_r_reg     <= pend_r_reg;
            out_b_reg     <= pend_b_reg;
            out_valid_reg <= 1'b1;
            out_last_reg  <= cmd.flush;
        end
        else if (cmd.flush)
        begin
            out_l_reg     <= '0;
            out_t_reg     <= '0;
            out_r_reg     <= '0;
            out_b_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b1;
        end
    end

    assign strobe      = strobe_reg;
    assign rect_left   = out_l_reg;
    assign rect_top    = out_t_reg;
    assign rect_right  = out_r_reg;
    assign rect_bottom = out_b_reg;
    assign rect_valid  = out_valid_reg;
    assign last_rect   = out_last_reg;

endmodule

### design/greedy_mask_rect_packer.sv
// ---------------------------------------------------------------------------
// greedy_mask_rect_packer: tile hit mask to pixel rectangle packer
// Loads a tile hit mask one row word at a time and, after the last row,
// covers its set cells greedily with rectangles clipped to the framebuffer.
// ---------------------------------------------------------------------------
// A row word is taken with start whenever busy is low. The word that
// completes the mask (row gh-1, gh being grid_height clamped to 1..MAX_ROWS)
// starts packing and raises busy from the next cycle. Packing shifts past
// each empty top row, runs find, multiply and clip for each rectangle
// found, makes one more find step that sees no set cell left and then
// flushes, all sequenced by the controller. Every result word appears for
// exactly one cycle with strobe high and the receiver has no way to hold it
// off. A clipped rectangle that is kept waits in a one-deep pending stage and
// goes out in the cycle after the next kept rectangle is clipped, or in
// the cycle after the flush, so that the last word of a mask can carry last_rect;
// an empty mask gives one word with rect_valid low. Configuration writes take
// effect at the clock edge where cfg_write is high and are meant for times
// when busy is low and no result word is still due.
// ---------------------------------------------------------------------------
module greedy_mask_rect_packer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [gmrp_pkg::ROW_W-1:0]           row_bits,
    input  logic                                 cfg_write,
    input  logic [gmrp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gmrp_pkg::COORD_W-1:0]         cfg_data,
    output logic                                 strobe,
    output logic [gmrp_pkg::COORD_W-1:0]         rect_left,
    output logic [gmrp_pkg::COORD_W-1:0]         rect_top,
    output logic [gmrp_pkg::COORD_W-1:0]         rect_right,
    output logic [gmrp_pkg::COORD_W-1:0]         rect_bottom,
    output logic                                 rect_valid,
    output logic                                 last_rect
);
    import gmrp_pkg::*;

    gmrp_cmd_t                 cmd;
    gmrp_stat_t                stat;

    logic [DIM_W-1:0]          grid_width_reg;
    logic [DIM_W-1:0]          grid_height_reg;
    logic [TILE_W-1:0]         tile_size_reg;
    logic signed [COORD_W-1:0] origin_x_reg;
    logic signed [COORD_W-1:0] origin_y_reg;
    logic [COORD_W-1:0]        frame_width_reg;
    logic [COORD_W-1:0]        frame_height_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg   <= DIM_W'(MAX_COLS);
            grid_height_reg  <= DIM_W'(MAX_ROWS);
            tile_size_reg    <= TILE_W'(128);
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            frame_width_reg  <= COORD_W'(4096);
            frame_height_reg <= COORD_W'(4096);
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GRID_WIDTH:   grid_width_reg   <= cfg_data[DIM_W-1:0];
                REG_GRID_HEIGHT:  grid_height_reg  <= cfg_data[DIM_W-1:0];
                REG_TILE_SIZE:    tile_size_reg    <= cfg_data[TILE_W-1:0];
                REG_ORIGIN_X:     origin_x_reg     <= cfg_data;
                REG_ORIGIN_Y:     origin_y_reg     <= cfg_data;
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Sequencer
    gmrp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    // Datapath
    gmrp_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .row_bits     (row_bits),
        .grid_width   (grid_width_reg),
        .grid_height  (grid_height_reg),
        .tile_size    (tile_size_reg),
        .origin_x     (origin_x_reg),
        .origin_y     (origin_y_reg),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .strobe       (strobe),
        .rect_left    (rect_left),
        .rect_top     (rect_top),
        .rect_right   (rect_right),
        .rect_bottom  (rect_bottom),
        .rect_valid   (rect_valid),
        .last_rect    (last_rect)
    );

endmodule
